>>> rtl/core/magnetometer_calibration_heading_core_macros.svh
// ----------------------------------------------------------------------------
// Magnetometer calibration assertion macros
// Shared property macros for the checker of the calibration and heading core.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_CALIBRATION_HEADING_CORE_MACROS_SVH
`define MAGNETOMETER_CALIBRATION_HEADING_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked at the next clock edge.
`define MCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/mch_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration package
// Widths, command codes and the arctangent table shared by the core modules.
// ----------------------------------------------------------------------------
package mch_pkg;

    localparam int SAMPLE_BITS_DEF      = 13;
    localparam int SCALE_FRAC_BITS_DEF  = 12;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    localparam int OUT_BITS   = 18;
    localparam int HEAD_BITS  = 15;
    localparam int SCALE_BITS = 16;
    localparam int ANGLE_BITS = 34;
    localparam int TURN_UNITS = 23040;
    localparam int AXES       = 3;

    typedef enum logic [1:0] {
        CMD_TRACK    = 2'd0,
        CMD_FINALIZE = 2'd1,
        CMD_HEADING  = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [21:0] arc_of(input logic [4:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/core/mch_lane.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration axis lane
// One axis: min/max tracking, finalize divider and sample correction.
// ----------------------------------------------------------------------------
module mch_lane #(
    parameter int SAMPLE_BITS     = mch_pkg::SAMPLE_BITS_DEF,
    parameter int SCALE_FRAC_BITS = mch_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear_store,
    input  logic                                track,
    input  logic                                div_start,
    input  logic [SAMPLE_BITS+1:0]              span_sum,
    input  logic                                corr_start,
    input  logic                                calibrated,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic [SAMPLE_BITS:0]                span,
    output logic signed [mch_pkg::OUT_BITS-1:0] corrected
);

    localparam int SB   = SAMPLE_BITS;
    localparam int NUMW = SB + 2 + SCALE_FRAC_BITS;
    localparam int DENW = SB + 3;
    localparam int CNTW = $clog2(NUMW + 1);
    localparam int DW   = SB + 2;
    localparam int PW   = DW + mch_pkg::SCALE_BITS;
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [mch_pkg::SCALE_BITS-1:0] UNITY =
        mch_pkg::SCALE_BITS'(1 << SCALE_FRAC_BITS);

    logic signed [SB-1:0] min_reg, max_reg;
    logic signed [SB:0]   offd_reg;
    logic [mch_pkg::SCALE_BITS-1:0] scale_reg;
    logic [NUMW-1:0] rem_num_reg, rem_num_next;
    logic [DENW:0]   rem_reg, rem_next;
    logic [NUMW-1:0] quo_reg, quo_next;
    logic [DENW-1:0] den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic [DENW:0]   trial;
    logic signed [DW-1:0] d;
    logic [DW-1:0]   dmag;
    logic [PW-1:0]   prod_reg;
    logic            dneg_reg;
    logic [PW-1:0]   mag;
    logic signed [mch_pkg::OUT_BITS:0] q;

    assign span = (SB+1)'($signed({max_reg[SB-1], max_reg}) - $signed({min_reg[SB-1], min_reg}));

    // Restoring divide, one quotient bit per cycle.
    always_comb
    begin
        trial        = {rem_reg[DENW-1:0], rem_num_reg[NUMW-1]};
        rem_next     = trial;
        quo_next     = {quo_reg[NUMW-2:0], 1'b0};
        rem_num_next = {rem_num_reg[NUMW-2:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next    = trial - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= SMAX;
            max_reg   <= SMIN;
            offd_reg  <= '0;
            scale_reg <= UNITY;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (clear_store)
        begin
            min_reg   <= SMAX;
            max_reg   <= SMIN;
            offd_reg  <= '0;
            scale_reg <= UNITY;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (track)
            begin
                if (sample < min_reg) min_reg <= sample;
                if (sample > max_reg) max_reg <= sample;
            end
            if (div_start)
            begin
                offd_reg    <= (SB+1)'($signed(max_reg) + $signed(min_reg));
                rem_num_reg <= NUMW'({span_sum, {SCALE_FRAC_BITS{1'b0}}});
                rem_reg     <= '0;
                quo_reg     <= '0;
                den_reg     <= DENW'(span) + DENW'({span, 1'b0});
                cnt_reg     <= CNTW'(NUMW);
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg     <= rem_next;
                quo_reg     <= quo_next;
                rem_num_reg <= rem_num_next;
                cnt_reg     <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    if (den_reg == '0 || quo_next > NUMW'(16'hFFFF))
                        scale_reg <= 16'hFFFF;
                    else
                        scale_reg <= quo_next[mch_pkg::SCALE_BITS-1:0];
                end
            end
        end
    end

    assign d    = DW'($signed({sample, 1'b0})) - DW'(offd_reg);
    assign dmag = d[DW-1] ? DW'(-d) : DW'(d);

    // Product registered, then shifted, saturated and signed.
    always_ff @(posedge clk)
    begin
        if (corr_start)
        begin
            prod_reg <= PW'(dmag) * PW'(scale_reg);
            dneg_reg <= d[DW-1];
        end
    end

    always_comb
    begin
        mag = prod_reg >> (SCALE_FRAC_BITS + 1);
        if (mag > PW'(131072)) mag = PW'(131072);
        q = dneg_reg ? -$signed({1'b0, mag[mch_pkg::OUT_BITS-1:0]})
                     : $signed({1'b0, mag[mch_pkg::OUT_BITS-1:0]});
        if (!dneg_reg && mag == PW'(131072)) q = 19'sd131071;
    end

    always_ff @(posedge clk)
    begin
        if (corr_start)
            corrected <= calibrated ? '0 : mch_pkg::OUT_BITS'(sample);
        else if (calibrated)
            corrected <= q[mch_pkg::OUT_BITS-1:0];
    end

endmodule

>>> rtl/core/mch_cordic.sv
// ----------------------------------------------------------------------------
// Magnetometer heading CORDIC
// Iterative vectoring CORDIC giving atan2 in 1/64 degree within one turn.
// ----------------------------------------------------------------------------
module mch_cordic #(
    parameter int ANGLE_ITERATIONS = mch_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [mch_pkg::OUT_BITS:0]    a,
    input  logic signed [mch_pkg::OUT_BITS:0]    b,
    output logic                                 done,
    output logic [mch_pkg::HEAD_BITS-1:0]        angle
);

    localparam int VW = mch_pkg::OUT_BITS + 12;
    localparam int AW = mch_pkg::ANGLE_BITS;
    localparam int IW = $clog2(ANGLE_ITERATIONS + 1);

    logic signed [VW-1:0] x_reg, y_reg, sx, sy;
    logic signed [AW-1:0] z_reg, hz;
    logic [IW-1:0]        i_reg;
    logic                 busy_reg, zero_reg, done_reg;
    logic signed [VW-1:0] x0, y0;
    logic signed [AW-1:0] h;

    assign x0 = VW'(b) <<< 8;
    assign y0 = VW'(a) <<< 8;
    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    assign hz = (z_reg + AW'(512)) >>> 10;

    always_comb
    begin
        h = hz;
        if (h < 0) h = h + AW'(mch_pkg::TURN_UNITS);
        if (h >= AW'(mch_pkg::TURN_UNITS)) h = h - AW'(mch_pkg::TURN_UNITS);
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : h[mch_pkg::HEAD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                zero_reg <= (a == '0) && (b == '0);
                if (x0 < 0)
                begin
                    x_reg <= -x0;
                    y_reg <= -y0;
                    z_reg <= (y0 >= 0) ? AW'(180 * 65536) : -AW'(180 * 65536);
                end
                else
                begin
                    x_reg <= x0;
                    y_reg <= y0;
                    z_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    z_reg <= z_reg + AW'(mch_pkg::arc_of(5'(i_reg)));
                end
                else
                begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    z_reg <= z_reg - AW'(mch_pkg::arc_of(5'(i_reg)));
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(ANGLE_ITERATIONS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/magnetometer_calibration_heading_core.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration and heading core
// Hard/soft-iron calibration of a three-axis sample and tilt-free heading.
// ----------------------------------------------------------------------------
// One beat in carries a command and a sample; one beat out follows. Track,
// clear and a finalize with nothing tracked pass through the correction,
// multiply and output states. A finalize that divides first waits on the
// bit-serial divider in each of the three axis lanes. Heading also runs the
// shared iterative CORDIC. The result beat shows up in the same cycle that
// the next input beat can first be taken. One item is worked at a time, and
// the input also stalls while a result waits on out_stall.
module magnetometer_calibration_heading_core #(
    parameter int SAMPLE_BITS      = mch_pkg::SAMPLE_BITS_DEF,
    parameter int SCALE_FRAC_BITS  = mch_pkg::SCALE_FRAC_BITS_DEF,
    parameter int ANGLE_ITERATIONS = mch_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic signed [SAMPLE_BITS-1:0]        sample_x,
    input  logic signed [SAMPLE_BITS-1:0]        sample_y,
    input  logic signed [SAMPLE_BITS-1:0]        sample_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mch_pkg::HEAD_BITS-1:0]        heading,
    output logic                                 heading_valid,
    output logic                                 is_calibrated,
    output logic signed [mch_pkg::OUT_BITS-1:0]  corrected_x,
    output logic signed [mch_pkg::OUT_BITS-1:0]  corrected_y,
    output logic signed [mch_pkg::OUT_BITS-1:0]  corrected_z
);

    localparam int DIVW = SAMPLE_BITS + 2 + SCALE_FRAC_BITS + 2;
    localparam int CW   = $clog2(DIVW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_CORR, S_MULT, S_ANGLE, S_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] wait_reg;
    logic [1:0] cmd_reg;
    logic signed [SAMPLE_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic sel_reg, cal_reg, seen_reg;
    logic accept, clr, trk, dstart, cstart, astart, adone;
    logic [SAMPLE_BITS:0] span_x, span_y, span_z;
    logic [SAMPLE_BITS+1:0] ssum;
    logic signed [mch_pkg::OUT_BITS-1:0] cx, cy, cz;
    logic signed [mch_pkg::OUT_BITS:0] ang_a, ang_b;
    logic [mch_pkg::HEAD_BITS-1:0] ang;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE) || (out_valid && out_stall);
    assign accept    = in_valid && !in_stall;

    assign clr    = (state_reg == S_CORR) && (cmd_reg == mch_pkg::CMD_CLEAR) && (wait_reg == '0);
    assign trk    = (state_reg == S_CORR) && (cmd_reg == mch_pkg::CMD_TRACK) && (wait_reg == '0);
    assign dstart = (state_reg == S_DIV) && (wait_reg == CW'(DIVW));
    assign cstart = (state_reg == S_CORR) && (wait_reg == CW'(1));
    assign astart = (state_reg == S_ANGLE) && (wait_reg == '0);
    assign ssum   = (SAMPLE_BITS+2)'(span_x) + (SAMPLE_BITS+2)'(span_y)
                  + (SAMPLE_BITS+2)'(span_z);

    mch_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_lane_x (
        .clk(clk), .rst_n(rst_n), .clear_store(clr), .track(trk), .div_start(dstart),
        .span_sum(ssum), .corr_start(cstart), .calibrated(cal_reg), .sample(sx_reg),
        .span(span_x), .corrected(cx));
    mch_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_lane_y (
        .clk(clk), .rst_n(rst_n), .clear_store(clr), .track(trk), .div_start(dstart),
        .span_sum(ssum), .corr_start(cstart), .calibrated(cal_reg), .sample(sy_reg),
        .span(span_y), .corrected(cy));
    mch_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_lane_z (
        .clk(clk), .rst_n(rst_n), .clear_store(clr), .track(trk), .div_start(dstart),
        .span_sum(ssum), .corr_start(cstart), .calibrated(cal_reg), .sample(sz_reg),
        .span(span_z), .corrected(cz));

    // The merge stage picks the axis pair and hands atan2(a, b) to the CORDIC.
    assign ang_a = sel_reg ? (mch_pkg::OUT_BITS+1)'(cx) : (mch_pkg::OUT_BITS+1)'(cy);
    assign ang_b = sel_reg ? -(mch_pkg::OUT_BITS+1)'(cy) : -(mch_pkg::OUT_BITS+1)'(cz);

    mch_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(astart), .a(ang_a), .b(ang_b),
        .done(adone), .angle(ang));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= '0;
            sel_reg   <= 1'b1;
            cal_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall && state_reg != S_OUT)
                out_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
                sel_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= cmd;
                        sx_reg  <= sample_x;
                        sy_reg  <= sample_y;
                        sz_reg  <= sample_z;
                        if (cmd == mch_pkg::CMD_FINALIZE && seen_reg)
                        begin
                            state_reg <= S_DIV;
                            wait_reg  <= CW'(DIVW);
                        end
                        else
                        begin
                            state_reg <= S_CORR;
                            wait_reg  <= '0;
                        end
                    end
                end
                S_DIV:
                begin
                    if (wait_reg == '0)
                    begin
                        cal_reg   <= 1'b1;
                        state_reg <= S_CORR;
                    end
                    else
                        wait_reg <= wait_reg - 1'b1;
                end
                S_CORR:
                begin
                    if (wait_reg == '0)
                    begin
                        if (clr)
                        begin
                            cal_reg  <= 1'b0;
                            seen_reg <= 1'b0;
                        end
                        if (trk)
                            seen_reg <= 1'b1;
                        wait_reg <= CW'(1);
                    end
                    else
                        state_reg <= S_MULT;
                end
                S_MULT:
                begin
                    wait_reg  <= '0;
                    state_reg <= (cmd_reg == mch_pkg::CMD_HEADING) ? S_ANGLE : S_OUT;
                end
                S_ANGLE:
                begin
                    wait_reg <= CW'(1);
                    if (adone)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid     <= 1'b1;
                        heading       <= (cmd_reg == mch_pkg::CMD_HEADING) ? ang : '0;
                        heading_valid <= (cmd_reg == mch_pkg::CMD_HEADING);
                        is_calibrated <= cal_reg;
                        corrected_x   <= cx;
                        corrected_y   <= cy;
                        corrected_z   <= cz;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/mch_checker.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration port checker
// Port-level properties of the calibration and heading core, bound to it.
// ----------------------------------------------------------------------------
`include "magnetometer_calibration_heading_core_macros.svh"

module mch_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [14:0] heading,
    input logic       heading_valid
);

    `MCH_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)
    `MCH_ASSERT_IMP(a_hv_heading, clk, rst_n, out_valid && !heading_valid, heading == '0)
    `MCH_ASSERT_IMP(a_range, clk, rst_n, out_valid, heading < 15'd23040)
    `MCH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(heading))

endmodule

bind magnetometer_calibration_heading_core mch_checker u_mch_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .heading(heading),
    .heading_valid(heading_valid));

>>> test/magnetometer_calibration_heading_core_tb.sv
// ----------------------------------------------------------------------------
// Magnetometer calibration and heading core testbench
// Walks a short table of directed beats, then well-formed track / finalize /
// heading sequences with random content, mixed with noise. Every result beat
// is checked field by field against a typed expectation or a behavioral
// predictor of the core. Both sides idle and stall at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module magnetometer_calibration_heading_core_tb;

    localparam int HALF_PERIOD  = 10;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 255;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_AT_ITEM = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // Arctangent of 2^-i in 1/65536 degree, one entry per vectoring step.
    localparam longint ARCTAN_STEP [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [mch_pkg::HEAD_BITS-1:0]       heading;
        logic                                heading_valid;
        logic                                is_calibrated;
        logic signed [mch_pkg::OUT_BITS-1:0] cx;
        logic signed [mch_pkg::OUT_BITS-1:0] cy;
        logic signed [mch_pkg::OUT_BITS-1:0] cz;
    } result_t;

    typedef struct {
        mch_pkg::cmd_t cmd;
        int            x;
        int            y;
        int            z;
        bit            typed;
        result_t       want;
    } beat_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic                                cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [1:0]                          cmd;
    logic signed [12:0]                  sample_x;
    logic signed [12:0]                  sample_y;
    logic signed [12:0]                  sample_z;
    logic                                out_valid;
    logic                                out_stall;
    logic [mch_pkg::HEAD_BITS-1:0]       heading;
    logic                                heading_valid;
    logic                                is_calibrated;
    logic signed [mch_pkg::OUT_BITS-1:0] corrected_x;
    logic signed [mch_pkg::OUT_BITS-1:0] corrected_y;
    logic signed [mch_pkg::OUT_BITS-1:0] corrected_z;

    // Calibration store as the core should hold it.
    bit      pair_xy;
    int      min_axis [3];
    int      max_axis [3];
    int      offset2_axis [3];
    longint  scale_axis [3];
    bit      calibrated;
    bit      tracked_any;

    result_t pending_results [$];
    int      cycle_count = 0;
    int      beats_sent;
    int      mismatches = 0;
    int      burst_left;

    magnetometer_calibration_heading_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .sample_z      (sample_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .heading       (heading),
        .heading_valid (heading_valid),
        .is_calibrated (is_calibrated),
        .corrected_x   (corrected_x),
        .corrected_y   (corrected_y),
        .corrected_z   (corrected_z)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** magnetometer_calibration_heading_core: FAILED **");
            $finish;
        end
    end

    function automatic void clear_store();
        for (int i = 0; i < 3; i++)
        begin
            min_axis[i]     = 4095;
            max_axis[i]     = -4096;
            offset2_axis[i] = 0;
            scale_axis[i]   = 4096;
        end
        calibrated  = 0;
        tracked_any = 0;
    endfunction

    // Hard/soft-iron correction of one axis, truncated toward zero, saturated.
    function automatic longint correct_axis(longint s, int i);
        longint d;
        longint mag;
        if (!calibrated)
            return s;
        d   = 2 * s - offset2_axis[i];
        mag = ((d < 0) ? -d : d) * scale_axis[i];
        mag = mag >> 13;
        if (mag > 131072)
            mag = 131072;
        mag = (d < 0) ? -mag : mag;
        if (mag > 131071)
            mag = 131071;
        return mag;
    endfunction

    // CORDIC angle of the vector (b, a) in 1/64 degree within one turn.
    function automatic logic [mch_pkg::HEAD_BITS-1:0] angle_of(longint a, longint b);
        longint vx;
        longint vy;
        longint acc;
        longint nx;
        longint h;
        if (a == 0 && b == 0)
            return '0;
        vx  = b * 256;
        vy  = a * 256;
        acc = 0;
        if (vx < 0)
        begin
            acc = (vy >= 0) ? 180 * 65536 : -180 * 65536;
            vx  = -vx;
            vy  = -vy;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (vy > 0)
            begin
                nx  = vx + (vy >>> i);
                vy  = vy - (vx >>> i);
                acc = acc + ARCTAN_STEP[i];
            end
            else
            begin
                nx  = vx - (vy >>> i);
                vy  = vy + (vx >>> i);
                acc = acc - ARCTAN_STEP[i];
            end
            vx = nx;
        end
        h = (acc + 512) >>> 10;
        while (h < 0)
            h += mch_pkg::TURN_UNITS;
        while (h >= mch_pkg::TURN_UNITS)
            h -= mch_pkg::TURN_UNITS;
        return h[mch_pkg::HEAD_BITS-1:0];
    endfunction

    // Applies one command beat to the store and returns the result it causes.
    function automatic result_t calibrate_and_head(mch_pkg::cmd_t c, int x, int y, int z);
        result_t r;
        longint  s [3];
        longint  cv [3];
        longint  span [3];
        longint  span_sum;
        longint  q;
        s[0] = longint'(x);
        s[1] = longint'(y);
        s[2] = longint'(z);
        case (c)
            mch_pkg::CMD_TRACK:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (s[i] < min_axis[i])
                        min_axis[i] = int'(s[i]);
                    if (s[i] > max_axis[i])
                        max_axis[i] = int'(s[i]);
                end
                tracked_any = 1;
            end
            mch_pkg::CMD_FINALIZE:
            begin
                if (tracked_any)
                begin
                    span_sum = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        span[i]  = longint'(max_axis[i] - min_axis[i]);
                        span_sum += span[i];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        offset2_axis[i] = max_axis[i] + min_axis[i];
                        if (span[i] == 0)
                            q = 65535;
                        else
                            q = (span_sum << 12) / (3 * span[i]);
                        scale_axis[i] = (q > 65535) ? 65535 : q;
                    end
                    calibrated = 1;
                end
            end
            mch_pkg::CMD_CLEAR:
                clear_store();
            default:
            begin
            end
        endcase
        for (int i = 0; i < 3; i++)
            cv[i] = correct_axis(s[i], i);
        r.heading = '0;
        if (c == mch_pkg::CMD_HEADING)
            r.heading = pair_xy ? angle_of(cv[0], -cv[1]) : angle_of(cv[1], -cv[2]);
        r.heading_valid = (c == mch_pkg::CMD_HEADING);
        r.is_calibrated = calibrated;
        r.cx = cv[0][mch_pkg::OUT_BITS-1:0];
        r.cy = cv[1][mch_pkg::OUT_BITS-1:0];
        r.cz = cv[2][mch_pkg::OUT_BITS-1:0];
        return r;
    endfunction

    // Offers one beat, with a random gap first when the current burst is spent,
    // and waits for it to be taken. The predictor runs on acceptance.
    task automatic send_beat(mch_pkg::cmd_t c, int x, int y, int z, bit typed,
                             result_t want);
        result_t r;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        sample_x <= x[12:0];
        sample_y <= y[12:0];
        sample_z <= z[12:0];
        do
            @(posedge clk);
        while (in_stall);
        r = calibrate_and_head(c, x, y, z);
        pending_results.push_back(typed ? want : r);
        beats_sent++;
    endtask

    task automatic send_checked(mch_pkg::cmd_t c, int x, int y, int z);
        result_t none;
        none = '{default: '0};
        send_beat(c, x, y, z, 1'b0, none);
    endtask

    // Takes the core to idle and writes the axis pair selection.
    task automatic write_pair_select(bit v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pair_xy = v;
        @(posedge clk);
    endtask

    function automatic int clip_sample(int v);
        return (v > 4095) ? 4095 : ((v < -4096) ? -4096 : v);
    endfunction

    function automatic int any_sample();
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    // One calibration run: optional clear, a cloud of tracked samples around a
    // random center, finalize, then headings of mixed kinds.
    task automatic calibration_run();
        int center [3];
        int radius [3];
        int pt [3];
        int n;
        if ($urandom_range(0, 3) != 0)
            send_checked(mch_pkg::CMD_CLEAR, any_sample(), any_sample(), any_sample());
        for (int i = 0; i < 3; i++)
        begin
            center[i] = any_sample();
            case ($urandom_range(0, 5))
                0: radius[i] = 0;
                1: radius[i] = $urandom_range(1, 4);
                2: radius[i] = 4096;
                default: radius[i] = $urandom_range(1, 2000);
            endcase
        end
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 3; i++)
                pt[i] = clip_sample(center[i] + int'($urandom_range(0, 2 * radius[i]))
                                    - radius[i]);
            send_checked(mch_pkg::CMD_TRACK, pt[0], pt[1], pt[2]);
        end
        send_checked(mch_pkg::CMD_FINALIZE, any_sample(), any_sample(), any_sample());
        n = $urandom_range(3, 15);
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case ($urandom_range(0, 5))
                    0: pt[i] = center[i];
                    1: pt[i] = any_sample();
                    default: pt[i] = clip_sample(center[i] + int'($urandom_range(0, 400))
                                                 - 200);
                endcase
            end
            send_checked(mch_pkg::CMD_HEADING, pt[0], pt[1], pt[2]);
        end
    endtask

    // Result checker: every accepted result beat against the oldest expectation.
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat at cycle %0d", cycle_count);
            end
            else
            begin
                w = pending_results.pop_front();
                if (heading !== w.heading || heading_valid !== w.heading_valid
                    || is_calibrated !== w.is_calibrated || corrected_x !== w.cx
                    || corrected_y !== w.cy || corrected_z !== w.cz)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch cycle %0d: exp h=%0d hv=%0b cal=%0b c=%0d,%0d,%0d",
                                 cycle_count, w.heading, w.heading_valid, w.is_calibrated,
                                 w.cx, w.cy, w.cz);
                        $display("    got h=%0d hv=%0b cal=%0b c=%0d,%0d,%0d",
                                 heading, heading_valid, is_calibrated,
                                 corrected_x, corrected_y, corrected_z);
                    end
                end
            end
        end
    end

    // Receiver stall pattern: a periodic pattern, random stalls and open
    // stretches take turns, and one long hold-off lets the core back up.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (!hold_done && beats_sent >= HOLD_AT_ITEM)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            case ((cycle_count / 700) % 3)
                0: out_stall <= ((cycle_count % 7) < 3);
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    beat_row_t directed [$];

    function automatic result_t typed_result(int h, bit hv, bit cal, int x, int y, int z);
        result_t r;
        r.heading       = h[mch_pkg::HEAD_BITS-1:0];
        r.heading_valid = hv;
        r.is_calibrated = cal;
        r.cx = x[mch_pkg::OUT_BITS-1:0];
        r.cy = y[mch_pkg::OUT_BITS-1:0];
        r.cz = z[mch_pkg::OUT_BITS-1:0];
        return r;
    endfunction

    function automatic void add_row(mch_pkg::cmd_t c, int x, int y, int z, bit typed,
                                    result_t w);
        beat_row_t b;
        b.cmd   = c;
        b.x     = x;
        b.y     = y;
        b.z     = z;
        b.typed = typed;
        b.want  = w;
        directed.push_back(b);
    endfunction

    initial
    begin
        result_t none;
        none        = '{default: '0};
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        cmd         = mch_pkg::CMD_TRACK;
        sample_x    = '0;
        sample_y    = '0;
        sample_z    = '0;
        beats_sent  = 0;
        burst_left  = 0;
        pair_xy     = 1'b1;
        clear_store();

        // Zero vector right after reset, and finalize with nothing tracked.
        add_row(mch_pkg::CMD_HEADING, 0, 0, 0, 1, typed_result(0, 1, 0, 0, 0, 0));
        add_row(mch_pkg::CMD_FINALIZE, 100, -5, 7, 1, typed_result(0, 0, 0, 100, -5, 7));
        add_row(mch_pkg::CMD_HEADING, 4095, -4096, 0, 0, none);
        add_row(mch_pkg::CMD_HEADING, -4096, 4095, -1, 0, none);
        add_row(mch_pkg::CMD_HEADING, 0, -100, 0, 0, none);
        // Full-range calibration with equal spans.
        add_row(mch_pkg::CMD_TRACK, -4096, -4096, -4096, 0, none);
        add_row(mch_pkg::CMD_TRACK, 4095, 4095, 4095, 0, none);
        add_row(mch_pkg::CMD_FINALIZE, 0, 0, 0, 0, none);
        add_row(mch_pkg::CMD_HEADING, 4095, -4096, 4095, 0, none);
        add_row(mch_pkg::CMD_HEADING, -4096, 4095, 0, 0, none);
        add_row(mch_pkg::CMD_CLEAR, 1, 2, 3, 1, typed_result(0, 0, 0, 1, 2, 3));
        // Zero span on every axis: scales saturate, the center reads as zero.
        add_row(mch_pkg::CMD_TRACK, 10, 10, 10, 0, none);
        add_row(mch_pkg::CMD_FINALIZE, 0, 0, 0, 0, none);
        add_row(mch_pkg::CMD_HEADING, 10, 10, 10, 1, typed_result(0, 1, 1, 0, 0, 0));
        add_row(mch_pkg::CMD_HEADING, 11, 9, 10, 0, none);
        add_row(mch_pkg::CMD_HEADING, 4095, -4096, -4096, 0, none);
        // One narrow axis among wide ones: that scale overflows and saturates.
        add_row(mch_pkg::CMD_CLEAR, 0, 0, 0, 0, none);
        add_row(mch_pkg::CMD_TRACK, -4096, 0, -4096, 0, none);
        add_row(mch_pkg::CMD_TRACK, 4095, 1, 4095, 0, none);
        add_row(mch_pkg::CMD_FINALIZE, 0, 0, 0, 0, none);
        add_row(mch_pkg::CMD_HEADING, -1, 1, 0, 0, none);
        add_row(mch_pkg::CMD_TRACK, -4096, -4096, -4096, 0, none);
        add_row(mch_pkg::CMD_HEADING, -3000, 1, 2000, 0, none);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_beat(directed[i].cmd, directed[i].x, directed[i].y, directed[i].z,
                      directed[i].typed, directed[i].want);

        // Random phases alternate the axis pair selection.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_pair_select(phase[0]);
            for (int goal = beats_sent + PHASE_ITEMS; beats_sent < goal; )
            begin
                if ($urandom_range(0, 9) < 8)
                    calibration_run();
                else
                    repeat ($urandom_range(1, 5))
                        send_checked(mch_pkg::cmd_t'($urandom_range(0, 3)), any_sample(),
                                     any_sample(), any_sample());
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** magnetometer_calibration_heading_core: PASSED **");
        else
            $display("** magnetometer_calibration_heading_core: FAILED **");
        $finish;
    end

endmodule
